// ===== rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Defines the request and response beats, the queue entry and register codes.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int CalibWidth = 48;
   localparam int DivSteps = 32;
   localparam int QueueDepth = 4;
   localparam int QueueAw = 2;

   typedef enum logic [1:0] {
      REG_CALIB_T  = 2'd0,
      REG_CALIB_PA = 2'd1,
      REG_CALIB_PB = 2'd2,
      REG_CALIB_PC = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  press_msb;
      logic [7:0]  press_lsb;
      logic [7:0]  press_xlsb;
      logic [7:0]  temp_msb;
      logic [7:0]  temp_lsb;
      logic [7:0]  temp_xlsb;
      logic [31:0] sample_time;
      logic        last_sample;
   } req_type;

   typedef struct packed {
      logic               sample_valid;
      logic               pressure_valid;
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_pa;
      logic [31:0]        result_time;
      logic               last_result;
   } rsp_type;

   // front to back: classified sample
   typedef struct packed {
      logic        sample_valid;
      logic [19:0] adc_p;
      logic [19:0] adc_t;
      logic [31:0] sample_time;
      logic        last_sample;
   } item_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
      asr32 = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

endpackage

// ===== rtl/pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// pressure_temp_compensation_unit: barometric sample compensation
// An accepted sample passes the front register, the queue, the back
// pipeline and the output register before rsp_valid rises; one sample per
// cycle. The pressure divider is fully pipelined, one quotient bit per stage.
// Synchronous reset clears the pipeline valid bits and all calibration registers to 0.
// busy stays low; the response side cannot stall.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ptc_pkg::req_type                req_data,
   input  logic                            csr_write,
   input  logic [1:0]                      csr_index,
   input  logic [ptc_pkg::CalibWidth-1:0]  csr_data,
   output logic                            rsp_valid,
   output ptc_pkg::rsp_type                rsp_data
);

   logic [ptc_pkg::CalibWidth-1:0] ct_ff, pa_ff, pb_ff, pc_ff;
   logic              f_valid, q_valid;
   ptc_pkg::item_type f_data, q_data;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ct_ff <= '0;
         pa_ff <= '0;
         pb_ff <= '0;
         pc_ff <= '0;
      end else if (csr_write) begin
         case (ptc_pkg::reg_index_type'(csr_index))
            ptc_pkg::REG_CALIB_T:  ct_ff <= csr_data;
            ptc_pkg::REG_CALIB_PA: pa_ff <= csr_data;
            ptc_pkg::REG_CALIB_PB: pb_ff <= csr_data;
            ptc_pkg::REG_CALIB_PC: pc_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ptc_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .item_valid(f_valid), .item_data(f_data)
   );

   ptc_queue u_queue (
      .clock(clock), .reset(reset), .push(f_valid), .push_data(f_data),
      .pop_valid(q_valid), .pop_data(q_data)
   );

   ptc_back u_back (
      .clock(clock), .reset(reset),
      .calib_t(ct_ff), .calib_pa(pa_ff), .calib_pb(pb_ff), .calib_pc(pc_ff),
      .in_valid(q_valid), .in_data(q_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

endmodule

// ===== rtl/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front: accept and classify raw sensor samples
// Packs the raw readings, flags all-zero pressure and writes the queue.
// ----------------------------------------------------------------------------
module ptc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ptc_pkg::req_type     req_data,
   output logic                 item_valid,
   output ptc_pkg::item_type    item_data
);

   logic              item_valid_ff;
   ptc_pkg::item_type item_data_ff, item_data_in;

   always_comb begin
      item_data_in.sample_valid = (req_data.press_msb != 8'd0) ||
         (req_data.press_lsb != 8'd0) || (req_data.press_xlsb != 8'd0);
      item_data_in.adc_p = {req_data.press_msb, req_data.press_lsb, req_data.press_xlsb[7:4]};
      item_data_in.adc_t = {req_data.temp_msb, req_data.temp_lsb, req_data.temp_xlsb[7:4]};
      item_data_in.sample_time = req_data.sample_time;
      item_data_in.last_sample = req_data.last_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= start;
      end
      item_data_ff <= item_data_in;
   end

   assign item_valid = item_valid_ff;
   assign item_data  = item_data_ff;

endmodule

// ===== rtl/ptc_queue.sv =====
// ----------------------------------------------------------------------------
// ptc_queue: short queue between the front and the back
// Holds classified beats; the back drains one per cycle.
// ----------------------------------------------------------------------------
module ptc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptc_pkg::item_type push_data,
   output logic              pop_valid,
   output ptc_pkg::item_type pop_data
);

   ptc_pkg::item_type mem_ff [ptc_pkg::QueueDepth];
   logic [ptc_pkg::QueueAw:0] wr_ff, rd_ff;
   logic pop;

   assign pop_valid = (wr_ff != rd_ff);
   assign pop = pop_valid;
   assign pop_data = mem_ff[rd_ff[ptc_pkg::QueueAw-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
      end
      if (push) mem_ff[wr_ff[ptc_pkg::QueueAw-1:0]] <= push_data;
   end

endmodule

// ===== rtl/ptc_back.sv =====
// ----------------------------------------------------------------------------
// ptc_back: compensation pipeline
// Temperature and pressure math in multiply stages, then a pipelined
// restoring divider of one quotient bit per stage, then the final correction.
// ----------------------------------------------------------------------------
module ptc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ptc_pkg::CalibWidth-1:0]  calib_t,
   input  logic [ptc_pkg::CalibWidth-1:0]  calib_pa,
   input  logic [ptc_pkg::CalibWidth-1:0]  calib_pb,
   input  logic [ptc_pkg::CalibWidth-1:0]  calib_pc,
   input  logic                            in_valid,
   input  ptc_pkg::item_type               in_data,
   output logic                            rsp_valid,
   output ptc_pkg::rsp_type                rsp_data
);

   localparam int NS = 9;
   localparam int ND = ptc_pkg::DivSteps;

   typedef struct packed {
      logic        sv;
      logic [19:0] adc_p;
      logic [31:0] tm;
      logic        last;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
      logic [31:0] f;
   } st_type;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, calib_t[15:0]};
   assign t2 = ptc_pkg::sx16(calib_t[31:16]);
   assign t3 = ptc_pkg::sx16(calib_t[47:32]);
   assign p1 = {16'd0, calib_pa[15:0]};
   assign p2 = ptc_pkg::sx16(calib_pa[31:16]);
   assign p3 = ptc_pkg::sx16(calib_pa[47:32]);
   assign p4 = ptc_pkg::sx16(calib_pb[15:0]);
   assign p5 = ptc_pkg::sx16(calib_pb[31:16]);
   assign p6 = ptc_pkg::sx16(calib_pb[47:32]);
   assign p7 = ptc_pkg::sx16(calib_pc[15:0]);
   assign p8 = ptc_pkg::sx16(calib_pc[31:16]);
   assign p9 = ptc_pkg::sx16(calib_pc[47:32]);

   logic   v_ff [NS];
   st_type s_ff [NS];
   st_type s_in [NS-1];
   st_type s8_in;

   always_comb begin
      logic [31:0] adc_t, tf, v1, q, dd;
      for (int i = 0; i < NS-1; i++) s_in[i] = '0;
      adc_t = {12'd0, in_data.adc_t};
      // stage 0
      s_in[0].sv = in_data.sample_valid;
      s_in[0].adc_p = in_data.adc_p;
      s_in[0].tm = in_data.sample_time;
      s_in[0].last = in_data.last_sample;
      s_in[0].a = ((adc_t >> 3) - (t1 << 1)) * t2;
      dd = (adc_t >> 4) - t1;
      s_in[0].b = dd * dd;
      // stage 1
      s_in[1] = s_ff[0];
      s_in[1].b = ptc_pkg::asr32(s_ff[0].b, 12) * t3;
      // stage 2: t_fine
      s_in[2] = s_ff[1];
      tf = ptc_pkg::asr32(s_ff[1].a, 11) + ptc_pkg::asr32(s_ff[1].b, 14);
      s_in[2].a = tf;
      s_in[2].b = tf * 32'd5;
      v1 = ptc_pkg::asr32(tf, 1) - 32'd64000;
      q = ptc_pkg::asr32(v1, 2);
      s_in[2].c = v1;
      s_in[2].d = q * q;
      // stage 3
      s_in[3] = s_ff[2];
      s_in[3].a = ptc_pkg::asr32(s_ff[2].b + 32'd128, 8);
      s_in[3].b = ptc_pkg::asr32(s_ff[2].d, 11) * p6;
      s_in[3].e = s_ff[2].c * p5;
      s_in[3].f = p2 * s_ff[2].c;
      s_in[3].d = ptc_pkg::asr32(s_ff[2].d, 13);
      // stage 4
      s_in[4] = s_ff[3];
      s_in[4].b = ptc_pkg::asr32(s_ff[3].b + (s_ff[3].e << 1), 2) + (p4 << 16);
      s_in[4].d = p3 * s_ff[3].d;
      // stage 5
      s_in[5] = s_ff[4];
      s_in[5].c = 32'd32768 + ptc_pkg::asr32(ptc_pkg::asr32(s_ff[4].d, 3) +
                  ptc_pkg::asr32(s_ff[4].f, 1), 18);
      s_in[5].e = ((32'd1048576 - {12'd0, s_ff[4].adc_p}) -
                  ptc_pkg::asr32(s_ff[4].b, 12));
      // stage 6
      s_in[6] = s_ff[5];
      s_in[6].c = ptc_pkg::asr32(s_ff[5].c * p1, 15);
      s_in[6].e = s_ff[5].e * 32'd3125;
      // stage 7: dividend select; d holds dividend, f holds 'doubles after' flag
      s_in[7] = s_ff[6];
      s_in[7].d = s_ff[6].e[31] ? s_ff[6].e : (s_ff[6].e << 1);
      s_in[7].f = {31'd0, s_ff[6].e[31]};
   end

   // divider pipeline: rem in b, quotient bits in d (shift), divisor in c
   st_type dv_ff [ND+1];
   st_type dv_in [ND+1];
   logic   dvv_ff [ND+1];
   logic [32:0] rem [ND];
   logic [32:0] trial [ND];

   always_comb begin
      dv_in[0] = s_ff[7];
      dv_in[0].b = '0;
      for (int i = 0; i < ND; i++) begin
         rem[i] = {dv_ff[i].b, dv_ff[i].d[31]};
         trial[i] = rem[i] - {1'b0, dv_ff[i].c};
         dv_in[i+1] = dv_ff[i];
         if (!trial[i][32]) begin
            dv_in[i+1].b = trial[i][31:0];
            dv_in[i+1].d = {dv_ff[i].d[30:0], 1'b1};
         end else begin
            dv_in[i+1].b = rem[i][31:0];
            dv_in[i+1].d = {dv_ff[i].d[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
         for (int i = 0; i <= ND; i++) dvv_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NS-1; i++) v_ff[i] <= v_ff[i-1];
         dvv_ff[0] <= v_ff[NS-2];
         for (int i = 1; i <= ND; i++) dvv_ff[i] <= dvv_ff[i-1];
         v_ff[NS-1] <= dvv_ff[ND];
      end
      for (int i = 0; i < NS-1; i++) s_ff[i] <= s_in[i];
      for (int i = 0; i <= ND; i++) dv_ff[i] <= dv_in[i];
      s_ff[NS-1] <= s8_in;
   end

   // post-division: p in s8_in.e, products in b and f
   always_comb begin
      logic [31:0] p, p3s;
      s8_in = dv_ff[ND];
      p = dv_ff[ND].f[0] ? (dv_ff[ND].d << 1) : dv_ff[ND].d;
      p3s = p >> 3;
      s8_in.e = p;
      s8_in.b = (p3s * p3s) >> 13;
      s8_in.f = (p >> 2) * p8;
   end

   logic [31:0] pfin, m9;
   logic        rv_ff;
   ptc_pkg::rsp_type r_ff, r_in;

   always_comb begin
      m9 = p9 * s_ff[8].b;
      pfin = s_ff[8].e + ptc_pkg::asr32(ptc_pkg::asr32(m9, 12) +
             ptc_pkg::asr32(s_ff[8].f, 13) + p7, 4);
      r_in.sample_valid = s_ff[8].sv;
      r_in.pressure_valid = s_ff[8].sv && (s_ff[8].c != 32'd0);
      r_in.temperature_centi = s_ff[8].sv ? s_ff[8].a : 32'd0;
      r_in.pressure_pa = r_in.pressure_valid ? pfin : 32'd0;
      r_in.result_time = s_ff[8].tm;
      r_in.last_result = s_ff[8].last;
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= v_ff[8];
      r_ff <= r_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = r_ff;

endmodule

// ===== test/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker: scoreboard for the pressure/temperature compensation unit
// Tracks calibration writes, computes the compensated result of every accepted
// request beat and compares each response beat with the oldest expectation.
// ----------------------------------------------------------------------------
module ptc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  ptc_pkg::req_type                req_data,
   input  logic                            csr_write,
   input  logic [1:0]                      csr_index,
   input  logic [ptc_pkg::CalibWidth-1:0]  csr_data,
   input  logic                            rsp_valid,
   input  ptc_pkg::rsp_type                rsp_data,
   output int                              errors,
   output int                              outstanding
);

   logic [47:0]      calib [4];
   ptc_pkg::rsp_type pending_results [$];

   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      logic signed [31:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [31:0] sgn(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic ptc_pkg::rsp_type compensate(input ptc_pkg::req_type r);
      ptc_pkg::rsp_type o;
      logic [31:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] v1, v2, d, t_fine, q, p;
      o = '0;
      o.result_time = r.sample_time;
      o.last_result = r.last_sample;
      if (r.press_msb != 0 || r.press_lsb != 0 || r.press_xlsb != 0) begin
         adc_p = {12'd0, r.press_msb, r.press_lsb, r.press_xlsb[7:4]};
         adc_t = {12'd0, r.temp_msb, r.temp_lsb, r.temp_xlsb[7:4]};
         t1 = {16'd0, calib[0][15:0]};
         t2 = sgn(calib[0][31:16]);
         t3 = sgn(calib[0][47:32]);
         p1 = {16'd0, calib[1][15:0]};
         p2 = sgn(calib[1][31:16]);
         p3 = sgn(calib[1][47:32]);
         p4 = sgn(calib[2][15:0]);
         p5 = sgn(calib[2][31:16]);
         p6 = sgn(calib[2][47:32]);
         p7 = sgn(calib[3][15:0]);
         p8 = sgn(calib[3][31:16]);
         p9 = sgn(calib[3][47:32]);
         o.sample_valid = 1'b1;
         v1 = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
         d = (adc_t >> 4) - t1;
         v2 = sra(sra(d * d, 12) * t3, 14);
         t_fine = v1 + v2;
         o.temperature_centi = sra(t_fine * 32'd5 + 32'd128, 8);
         v1 = sra(t_fine, 1) - 32'd64000;
         q = sra(v1, 2);
         v2 = sra(q * q, 11) * p6;
         v2 = v2 + ((v1 * p5) << 1);
         v2 = sra(v2, 2) + (p4 << 16);
         v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
         v1 = sra((32'd32768 + v1) * p1, 15);
         if (v1 != 0) begin
            p = ((32'd1048576 - adc_p) - sra(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = sra((p >> 2) * p8, 13);
            p = p + sra(v1 + v2 + p7, 4);
            o.pressure_pa = p;
            o.pressure_valid = 1'b1;
         end
      end
      return o;
   endfunction

   assign outstanding = pending_results.size();

   always @(posedge clock) begin
      ptc_pkg::rsp_type e;
      if (reset) begin
         for (int i = 0; i < 4; i++) calib[i] <= '0;
         pending_results.delete();
         errors <= 0;
      end else begin
         if (csr_write) calib[csr_index] <= csr_data;
         if (start && !busy) pending_results.push_back(compensate(req_data));
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("response beat with no expectation");
               errors <= errors + 1;
            end else begin
               e = pending_results.pop_front();
               if (rsp_data !== e) errors <= errors + 1;
               if (rsp_data.sample_valid !== e.sample_valid)
                  $error("sample_valid exp %0d got %0d", e.sample_valid,
                         rsp_data.sample_valid);
               if (rsp_data.pressure_valid !== e.pressure_valid)
                  $error("pressure_valid exp %0d got %0d", e.pressure_valid,
                         rsp_data.pressure_valid);
               if (rsp_data.temperature_centi !== e.temperature_centi)
                  $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                         rsp_data.temperature_centi);
               if (rsp_data.pressure_pa !== e.pressure_pa)
                  $error("pressure_pa exp %0d got %0d", e.pressure_pa,
                         rsp_data.pressure_pa);
               if (rsp_data.result_time !== e.result_time)
                  $error("result_time exp %h got %h", e.result_time,
                         rsp_data.result_time);
               if (rsp_data.last_result !== e.last_result)
                  $error("last_result exp %0d got %0d", e.last_result,
                         rsp_data.last_result);
            end
         end
      end
   end

endmodule

// ===== test/tb_pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pressure_temp_compensation_unit: stimulus and verdict
// Runs several calibration settings, directed edge samples and random bursts
// with random gaps (none in the last burst); the checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb_pressure_temp_compensation_unit;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   ptc_pkg::req_type               req_data = '0;
   logic                           csr_write = 1'b0;
   logic [1:0]                     csr_index = '0;
   logic [ptc_pkg::CalibWidth-1:0] csr_data = '0;
   logic                           rsp_valid;
   ptc_pkg::rsp_type               rsp_data;
   int                             errors, outstanding;
   logic                           taken = 1'b0;
   int                             quiet_cycles = 0;
   int                             idle_pct = 22;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pressure_temp_compensation_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   ptc_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .errors(errors), .outstanding(outstanding)
   );

   always @(posedge clock) begin
      taken <= start && !busy && !reset;
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 5000) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_calib(input ptc_pkg::reg_index_type idx,
                              input logic [47:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic set_calib(input logic [47:0] t, input logic [47:0] pa,
                            input logic [47:0] pb, input logic [47:0] pc);
      write_calib(ptc_pkg::REG_CALIB_T, t);
      write_calib(ptc_pkg::REG_CALIB_PA, pa);
      write_calib(ptc_pkg::REG_CALIB_PB, pb);
      write_calib(ptc_pkg::REG_CALIB_PC, pc);
   endtask

   task automatic send_sample(input ptc_pkg::req_type r);
      if ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = r;
      @(negedge clock);
      while (!taken) @(negedge clock);
   endtask

   function automatic ptc_pkg::req_type random_sample();
      ptc_pkg::req_type r;
      r = ptc_pkg::req_type'({$urandom, $urandom, $urandom});
      case ($urandom_range(9))
         0: {r.press_msb, r.press_lsb, r.press_xlsb} = '0;
         1, 2, 3, 4: begin
            r.press_msb = 8'($urandom_range(8'hA0, 8'h40));
            r.temp_msb = 8'($urandom_range(8'h90, 8'h70));
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic drain();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic random_burst(input int count);
      repeat (count) send_sample(random_sample());
      drain();
   endtask

   localparam logic [47:0] TypT  = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [47:0] TypPA = {16'd3024, 16'hD643, 16'd36477};
   localparam logic [47:0] TypPB = {16'hFFF9, 16'd140, 16'd2855};
   localparam logic [47:0] TypPC = {16'd6000, 16'hC6F8, 16'd15500};

   initial begin
      ptc_pkg::req_type r;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // all calibration words zero: divisor zero
      random_burst(300);

      set_calib(TypT, TypPA, TypPB, TypPC);
      r = '0;
      send_sample(r);
      r.sample_time = 32'hFFFF_FFFF;
      r.last_sample = 1'b1;
      send_sample(r);
      r = '1;
      send_sample(r);
      r.last_sample = 1'b0;
      r.sample_time = '0;
      send_sample(r);
      r = '0;
      r.press_xlsb = 8'h0F;
      r.temp_xlsb = 8'h0F;
      send_sample(r);
      r.press_xlsb = 8'h10;
      send_sample(r);
      r = '0;
      r.press_msb = 8'h65;
      r.press_lsb = 8'h5A;
      r.press_xlsb = 8'hC0;
      r.temp_msb = 8'h7E;
      r.temp_lsb = 8'hED;
      r.temp_xlsb = 8'h00;
      send_sample(r);
      r.temp_msb = 8'hFF;
      send_sample(r);
      r.press_msb = 8'hFF;
      r.temp_msb = 8'h00;
      send_sample(r);
      random_burst(350);

      set_calib('1, '1, '1, '1);
      random_burst(300);

      set_calib({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'hFFFF},
                {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
      random_burst(300);

      set_calib(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      random_burst(300);

      idle_pct = 0;
      set_calib(TypT, TypPA, TypPB, TypPC);
      random_burst(450);

      if (errors == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
